>>> rtl/abb_pkg.sv
// Package for the alpha bounding box block.
// Holds shared constants, register index codes and the step control struct.
// No dependencies.
package abb_pkg;

  // Default largest frame dimension
  localparam int MAX_DIM_DEF = 4096;

  // Configuration port geometry
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  // Pixel alpha width
  localparam int ALPHA_W = 8;

  // Register index codes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_THRESHOLD = 2'd2;

  // Register reset values
  localparam logic [CFG_DATA_W-1:0] IMAGE_WIDTH_RST     = 13'd1;
  localparam logic [CFG_DATA_W-1:0] IMAGE_HEIGHT_RST    = 13'd1;
  localparam logic [ALPHA_W-1:0]    ALPHA_THRESHOLD_RST = 8'd0;

  // Control for one tracker step
  typedef struct packed {
    logic step;     // a pixel is consumed this cycle
    logic visible;  // its alpha exceeds the threshold
  } abb_ctrl_t;

endpackage

>>> rtl/alpha_bounding_box.sv
// Alpha bounding box: crop rectangle of the visible pixels of a raster frame.
// Throughput: one pixel transfer per cycle, limited by the single tracker update,
//   unless a frame's last pixel waits on a full, stalled result register.
// Frame result: via input register, then result register; other pixels give none.
// Reset: synchronous active-low rst_n resets counters, bounds, config and valids.
// Depends on abb_pkg, abb_cfg and abb_track.
module alpha_bounding_box #(
  parameter int MAX_DIM = abb_pkg::MAX_DIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration write port
  input  logic                           cfg_wr_en,
  input  logic [abb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [abb_pkg::CFG_DATA_W-1:0] cfg_data,
  // Pixel input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [abb_pkg::ALPHA_W-1:0]    in_alpha,
  // Result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [$clog2(MAX_DIM)-1:0]     out_crop_x,
  output logic [$clog2(MAX_DIM)-1:0]     out_crop_y,
  output logic [$clog2(MAX_DIM+1)-1:0]   out_crop_width,
  output logic [$clog2(MAX_DIM+1)-1:0]   out_crop_height,
  output logic                           out_found
);

  localparam int CW = $clog2(MAX_DIM);
  localparam int DW = $clog2(MAX_DIM + 1);

  // Configuration outputs
  logic [CW-1:0]               col_lim;
  logic [CW-1:0]               row_lim;
  logic [abb_pkg::ALPHA_W-1:0] threshold;

  // Input register stage
  logic                        s1_valid_r, s1_valid_nxt;
  logic [abb_pkg::ALPHA_W-1:0] s1_alpha_r, s1_alpha_nxt;

  // Tracker interface
  abb_pkg::abb_ctrl_t ctrl;
  logic               frame_end;
  logic [CW-1:0]      res_x, res_y;
  logic [DW-1:0]      res_w, res_h;
  logic               res_found;

  // Result register
  logic          out_valid_r, out_valid_nxt;
  logic [CW-1:0] crop_x_r, crop_x_nxt;
  logic [CW-1:0] crop_y_r, crop_y_nxt;
  logic [DW-1:0] crop_w_r, crop_w_nxt;
  logic [DW-1:0] crop_h_r, crop_h_nxt;
  logic          found_r,  found_nxt;

  logic in_xfer;
  logic out_xfer;
  logic consume;
  logic load_out;

  abb_cfg #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .col_lim   (col_lim),
    .row_lim   (row_lim),
    .threshold (threshold)
  );

  // The held pixel moves on unless it closes a frame while the result
  // register is still full and stalled.
  assign consume  = s1_valid_r && !(frame_end && out_valid_r && out_stall);
  assign in_stall = s1_valid_r && !consume;
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign load_out = consume && frame_end;

  assign ctrl.step    = consume;
  assign ctrl.visible = s1_valid_r && (s1_alpha_r > threshold);

  abb_track #(
    .MAX_DIM (MAX_DIM)
  ) u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .col_lim   (col_lim),
    .row_lim   (row_lim),
    .frame_end (frame_end),
    .res_x     (res_x),
    .res_y     (res_y),
    .res_w     (res_w),
    .res_h     (res_h),
    .res_found (res_found)
  );

  // Input register: take a new pixel when empty or whenever the held one advances
  always_comb begin
    s1_alpha_nxt = in_xfer ? in_alpha : s1_alpha_r;
    priority if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (consume) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  // Result register: load on frame end, drop after transfer, otherwise hold
  always_comb begin
    crop_x_nxt = load_out ? res_x     : crop_x_r;
    crop_y_nxt = load_out ? res_y     : crop_y_r;
    crop_w_nxt = load_out ? res_w     : crop_w_r;
    crop_h_nxt = load_out ? res_h     : crop_h_r;
    found_nxt  = load_out ? res_found : found_r;
    priority if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers need no reset
  always_ff @(posedge clk) begin
    s1_alpha_r <= s1_alpha_nxt;
    crop_x_r   <= crop_x_nxt;
    crop_y_r   <= crop_y_nxt;
    crop_w_r   <= crop_w_nxt;
    crop_h_r   <= crop_h_nxt;
    found_r    <= found_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_crop_x      = crop_x_r;
  assign out_crop_y      = crop_y_r;
  assign out_crop_width  = crop_w_r;
  assign out_crop_height = crop_h_r;
  assign out_found       = found_r;

endmodule

>>> rtl/abb_cfg.sv
// Configuration registers of the alpha bounding box block.
// Stores size and threshold, derives the last column and row indexes.
// Depends on abb_pkg.
module abb_cfg #(
  parameter int MAX_DIM = abb_pkg::MAX_DIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [abb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [abb_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [$clog2(MAX_DIM)-1:0]     col_lim,
  output logic [$clog2(MAX_DIM)-1:0]     row_lim,
  output logic [abb_pkg::ALPHA_W-1:0]    threshold
);

  localparam int CW = $clog2(MAX_DIM);
  localparam int EW = (abb_pkg::CFG_DATA_W > CW + 1) ? abb_pkg::CFG_DATA_W : CW + 1;

  logic [abb_pkg::CFG_DATA_W-1:0] width_r,  width_nxt;
  logic [abb_pkg::CFG_DATA_W-1:0] height_r, height_nxt;
  logic [abb_pkg::ALPHA_W-1:0]    thresh_r, thresh_nxt;

  // Clamp a size to 1..MAX_DIM and return size minus one
  function automatic logic [CW-1:0] last_index(input logic [abb_pkg::CFG_DATA_W-1:0] v);
    logic [EW-1:0] ext;
    ext = EW'(v);
    if (ext == '0) begin
      return '0;
    end else if (ext > EW'(MAX_DIM)) begin
      return CW'(MAX_DIM - 1);
    end else begin
      return CW'(ext - EW'(1));
    end
  endfunction

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    thresh_nxt = thresh_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        abb_pkg::REG_IMAGE_WIDTH:     width_nxt  = cfg_data;
        abb_pkg::REG_IMAGE_HEIGHT:    height_nxt = cfg_data;
        abb_pkg::REG_ALPHA_THRESHOLD: thresh_nxt = cfg_data[abb_pkg::ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= abb_pkg::IMAGE_WIDTH_RST;
      height_r <= abb_pkg::IMAGE_HEIGHT_RST;
      thresh_r <= abb_pkg::ALPHA_THRESHOLD_RST;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      thresh_r <= thresh_nxt;
    end
  end

  assign col_lim   = last_index(width_r);
  assign row_lim   = last_index(height_r);
  assign threshold = thresh_r;

endmodule

>>> rtl/abb_track.sv
// Raster position counters and bounding box tracker.
// Produces the frame-end flag and the crop rectangle for the current pixel.
// Depends on abb_pkg.
module abb_track #(
  parameter int MAX_DIM = abb_pkg::MAX_DIM_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  abb_pkg::abb_ctrl_t              ctrl,
  input  logic [$clog2(MAX_DIM)-1:0]      col_lim,
  input  logic [$clog2(MAX_DIM)-1:0]      row_lim,
  output logic                            frame_end,
  output logic [$clog2(MAX_DIM)-1:0]      res_x,
  output logic [$clog2(MAX_DIM)-1:0]      res_y,
  output logic [$clog2(MAX_DIM+1)-1:0]    res_w,
  output logic [$clog2(MAX_DIM+1)-1:0]    res_h,
  output logic                            res_found
);

  localparam int CW = $clog2(MAX_DIM);
  localparam int DW = $clog2(MAX_DIM + 1);
  localparam logic [CW-1:0] MIN_RST = CW'(MAX_DIM - 1);

  logic [CW-1:0] col_r,     col_nxt;
  logic [CW-1:0] row_r,     row_nxt;
  logic [CW-1:0] min_col_r, min_col_nxt;
  logic [CW-1:0] max_col_r, max_col_nxt;
  logic [CW-1:0] min_row_r, min_row_nxt;
  logic [CW-1:0] max_row_r, max_row_nxt;
  logic          any_r,     any_nxt;

  // Bounds including the current pixel
  logic [CW-1:0] min_col_u, max_col_u, min_row_u, max_row_u;
  logic          any_u;
  logic          row_end;

  always_comb begin
    min_col_u = min_col_r;
    max_col_u = max_col_r;
    min_row_u = min_row_r;
    max_row_u = max_row_r;
    any_u     = any_r;
    if (ctrl.visible) begin
      any_u = 1'b1;
      if (!any_r) begin
        min_col_u = col_r;
        max_col_u = col_r;
        min_row_u = row_r;
        max_row_u = row_r;
      end else begin
        if (col_r < min_col_r) min_col_u = col_r;
        if (col_r > max_col_r) max_col_u = col_r;
        if (row_r < min_row_r) min_row_u = row_r;
        if (row_r > max_row_r) max_row_u = row_r;
      end
    end
  end

  assign row_end   = (col_r >= col_lim);
  assign frame_end = row_end && (row_r >= row_lim);

  // Rectangle is zero when nothing was visible
  assign res_found = any_u;
  assign res_x     = any_u ? min_col_u : '0;
  assign res_y     = any_u ? min_row_u : '0;
  assign res_w     = any_u ? (DW'(max_col_u - min_col_u) + DW'(1)) : '0;
  assign res_h     = any_u ? (DW'(max_row_u - min_row_u) + DW'(1)) : '0;

  always_comb begin
    col_nxt     = col_r;
    row_nxt     = row_r;
    min_col_nxt = min_col_r;
    max_col_nxt = max_col_r;
    min_row_nxt = min_row_r;
    max_row_nxt = max_row_r;
    any_nxt     = any_r;
    if (ctrl.step) begin
      if (frame_end) begin
        col_nxt     = '0;
        row_nxt     = '0;
        min_col_nxt = MIN_RST;
        max_col_nxt = '0;
        min_row_nxt = MIN_RST;
        max_row_nxt = '0;
        any_nxt     = 1'b0;
      end else begin
        min_col_nxt = min_col_u;
        max_col_nxt = max_col_u;
        min_row_nxt = min_row_u;
        max_row_nxt = max_row_u;
        any_nxt     = any_u;
        if (row_end) begin
          col_nxt = '0;
          row_nxt = row_r + CW'(1);
        end else begin
          col_nxt = col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      min_col_r <= MIN_RST;
      max_col_r <= '0;
      min_row_r <= MIN_RST;
      max_row_r <= '0;
      any_r     <= 1'b0;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      min_col_r <= min_col_nxt;
      max_col_r <= max_col_nxt;
      min_row_r <= min_row_nxt;
      max_row_r <= max_row_nxt;
      any_r     <= any_nxt;
    end
  end

endmodule

>>> rtl/abb_checker.sv
// Port-level checker for the alpha bounding box block, with its bind.
// Depends on abb_pkg and the top-level alpha_bounding_box.
module abb_checker #(
  parameter int MAX_DIM = abb_pkg::MAX_DIM_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [$clog2(MAX_DIM)-1:0]   out_crop_x,
  input logic [$clog2(MAX_DIM)-1:0]   out_crop_y,
  input logic [$clog2(MAX_DIM+1)-1:0] out_crop_width,
  input logic [$clog2(MAX_DIM+1)-1:0] out_crop_height,
  input logic                         out_found
);

  // Hold a stalled result steady
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_crop_x) && $stable(out_crop_y)
      && $stable(out_crop_width) && $stable(out_crop_height) && $stable(out_found))
    else $error("stalled result changed");

  // No result right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Empty frame gives a zero rectangle
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_crop_x == '0 && out_crop_y == '0
      && out_crop_width == '0 && out_crop_height == '0)
    else $error("nonzero rectangle without visible pixel");

  // Found frame gives a nonempty rectangle
  a_found_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_crop_width != '0 && out_crop_height != '0)
    else $error("empty rectangle with visible pixel");

endmodule

bind alpha_bounding_box abb_checker #(
  .MAX_DIM (MAX_DIM)
) u_abb_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_crop_x      (out_crop_x),
  .out_crop_y      (out_crop_y),
  .out_crop_width  (out_crop_width),
  .out_crop_height (out_crop_height),
  .out_found       (out_found)
);
